### hw/rtl/ncs_pkg.sv
// ncs_pkg: types, command codes and helper functions shared by the spline block
// used by ncs_ctrl, ncs_datapath and natural_cubic_spline_coefficients
// no dependencies
package ncs_pkg;

    localparam int ADDR_W = 7;   // covers 3 * 22 words
    localparam int IDX_W  = 5;

    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_LD_FWD  = 4'd1;
    localparam logic [3:0] OP_LD_V1   = 4'd2;
    localparam logic [3:0] OP_LD_V0F  = 4'd3;
    localparam logic [3:0] OP_LD_BWD  = 4'd4;
    localparam logic [3:0] OP_LD_LO   = 4'd5;
    localparam logic [3:0] OP_LD_HI   = 4'd6;
    localparam logic [3:0] OP_TERM_PT = 4'd7;
    localparam logic [3:0] OP_TERM_D  = 4'd8;
    localparam logic [3:0] OP_MUL     = 4'd9;
    localparam logic [3:0] OP_FIN     = 4'd10;
    localparam logic [3:0] OP_EMIT    = 4'd11;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic [3:0]         segment_index;
        logic [1:0]         axis;
        logic signed [39:0] coef_a;
        logic signed [39:0] coef_b;
        logic signed [39:0] coef_c;
        logic signed [39:0] coef_d;
        logic               last_result;
        logic               overflow;
    } result_t;

    typedef struct packed {
        logic              capture;
        logic [3:0]        op;
        logic [1:0]        ax;
        logic [ADDR_W-1:0] pt_addr;
        logic              pt_we;
        logic [ADDR_W-1:0] fw_addr;
        logic              fw_we;
        logic [ADDR_W-1:0] dv_addr;
        logic              dv_we;
        logic              dv_sub;
        logic              use_f;
        logic [IDX_W-1:0]  gidx;
        logic              gend;
        logic [3:0]        seg;
        logic              last;
        logic              ovf;
    } cmd_t;

    typedef struct packed {
        logic last_point;
    } status_t;

    function automatic logic signed [39:0] sat40(logic signed [47:0] x);
        if (x > 48'sd549755813887)
            return 40'sh7FFFFFFFFF;
        else if (x < -48'sd549755813888)
            return 40'sh8000000000;
        else
            return x[39:0];
    endfunction

    // elaboration-time helpers for the gamma tables
    function automatic longint unsigned q_val(int i);
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        a = 64'd1;
        b = 64'd2;
        if (i == 0)
            return a;
        for (int k = 2; k <= i; k++)
        begin
            c = 64'd4 * b - a;
            a = b;
            b = c;
        end
        return b;
    endfunction

    function automatic logic [31:0] frac32(longint unsigned num, longint unsigned den);
        longint unsigned r;
        longint unsigned x;
        r = num;
        x = 64'd0;
        for (int k = 0; k < 33; k++)
        begin
            r = r << 1;
            x = x << 1;
            if (r >= den)
            begin
                r = r - den;
                x = x | 64'd1;
            end
        end
        x = (x + 64'd1) >> 1;
        return x[31:0];
    endfunction

    function automatic logic [31:0] gamma_int(int i);
        return frac32(q_val(i), q_val(i + 1));
    endfunction

    function automatic logic [31:0] gamma_end(int i);
        if (i == 0)
            return 32'd0;
        return frac32(q_val(i), 64'd2 * q_val(i) - q_val(i - 1));
    endfunction

endpackage

### hw/rtl/ncs_ram.sv
// ncs_ram: generic single-port ram with registered read
// no dependencies
module ncs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ncs_datapath.sv
// ncs_datapath: point, sweep and derivative stores, gamma multiply and coefficient output
// depends on ncs_pkg and ncs_ram
module ncs_datapath #(
    parameter int MAX_POINTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ncs_pkg::point_t  point,
    input  ncs_pkg::cmd_t    cmd,
    output ncs_pkg::status_t status,
    output ncs_pkg::result_t result,
    output logic             result_valid
);

    localparam int DEPTH = 3 * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int GW    = $clog2(MAX_POINTS);

    ncs_pkg::point_t    in_reg;
    logic signed [31:0] v0_reg, v1_reg;
    logic signed [39:0] f_reg, d0_reg, d1_reg;
    logic [41:0]        mag_reg;
    logic               neg_reg;
    logic [31:0]        g_reg;
    logic [57:0]        hi_reg;
    logic [48:0]        lo_reg;
    logic signed [43:0] m_reg;
    ncs_pkg::result_t   out_reg;
    logic               valid_reg;

    logic [31:0]        pt_rdata;
    logic [39:0]        fw_rdata, dv_rdata;
    logic [39:0]        fw_wdata, dv_wdata;
    logic signed [31:0] axis_in;
    logic signed [47:0] term;
    logic signed [47:0] c_full, d_full;
    logic [58:0]        sum;
    logic [42:0]        rnd;
    logic [31:0]        g_int_tab [MAX_POINTS];
    logic [31:0]        g_end_tab [MAX_POINTS];
    logic [GW-1:0]      gi;

    for (genvar k = 0; k < MAX_POINTS; k++)
    begin : g_tab
        assign g_int_tab[k] = ncs_pkg::gamma_int(k);
        assign g_end_tab[k] = ncs_pkg::gamma_end(k);
    end

    assign gi = cmd.gidx[GW-1:0];

    always_comb
    begin
        case (cmd.ax)
            2'd1:    axis_in = in_reg.point_y;
            2'd2:    axis_in = in_reg.point_z;
            default: axis_in = in_reg.point_x;
        endcase
    end

    always_comb
    begin
        if (cmd.op == ncs_pkg::OP_TERM_D)
            term = 48'(d1_reg);
        else
            term = (48'(v1_reg) - 48'(v0_reg)) * 48'sd3 - (cmd.use_f ? 48'(f_reg) : 48'sd0);
        sum = 59'(hi_reg) + 59'(lo_reg[48:16]);
        rnd = sum[58:16];
        c_full = (48'(v1_reg) - 48'(v0_reg)) * 48'sd3 - 48'(d0_reg) * 48'sd2 - 48'(d1_reg);
        d_full = (48'(v0_reg) - 48'(v1_reg)) * 48'sd2 + 48'(d0_reg) + 48'(d1_reg);
    end

    assign fw_wdata = ncs_pkg::sat40(48'(m_reg));
    assign dv_wdata = cmd.dv_sub ? ncs_pkg::sat40(48'(f_reg) - 48'(m_reg))
                                 : ncs_pkg::sat40(48'(m_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= point;
        case (cmd.op)
            ncs_pkg::OP_LD_FWD:
            begin
                v0_reg <= pt_rdata;
                f_reg  <= fw_rdata;
                v1_reg <= axis_in;
            end
            ncs_pkg::OP_LD_V1:
                v1_reg <= pt_rdata;
            ncs_pkg::OP_LD_V0F:
            begin
                v0_reg <= pt_rdata;
                f_reg  <= fw_rdata;
            end
            ncs_pkg::OP_LD_BWD:
            begin
                d1_reg <= dv_rdata;
                f_reg  <= fw_rdata;
            end
            ncs_pkg::OP_LD_LO:
            begin
                v0_reg <= pt_rdata;
                d0_reg <= dv_rdata;
            end
            ncs_pkg::OP_LD_HI:
            begin
                v1_reg <= pt_rdata;
                d1_reg <= dv_rdata;
            end
            ncs_pkg::OP_TERM_PT, ncs_pkg::OP_TERM_D:
            begin
                neg_reg <= term[47];
                mag_reg <= term[47] ? 42'(-term) : term[41:0];
                g_reg   <= cmd.gend ? g_end_tab[gi] : g_int_tab[gi];
            end
            ncs_pkg::OP_MUL:
            begin
                hi_reg <= 58'(mag_reg[41:16]) * 58'(g_reg);
                lo_reg <= 49'(mag_reg[15:0]) * 49'(g_reg) + 49'h80000000;
            end
            ncs_pkg::OP_FIN:
                m_reg <= neg_reg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
            ncs_pkg::OP_EMIT:
            begin
                out_reg.segment_index <= cmd.seg;
                out_reg.axis          <= cmd.ax;
                out_reg.coef_a        <= 40'(v0_reg);
                out_reg.coef_b        <= d0_reg;
                out_reg.coef_c        <= ncs_pkg::sat40(c_full);
                out_reg.coef_d        <= ncs_pkg::sat40(d_full);
                out_reg.last_result   <= cmd.last;
                out_reg.overflow      <= cmd.ovf;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= (cmd.op == ncs_pkg::OP_EMIT);
    end

    ncs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pt_ram (
        .clk   (clk),
        .we    (cmd.pt_we),
        .addr  (cmd.pt_addr[AW-1:0]),
        .wdata (axis_in),
        .rdata (pt_rdata)
    );

    ncs_ram #(.WIDTH(40), .DEPTH(DEPTH)) u_fw_ram (
        .clk   (clk),
        .we    (cmd.fw_we),
        .addr  (cmd.fw_addr[AW-1:0]),
        .wdata (fw_wdata),
        .rdata (fw_rdata)
    );

    ncs_ram #(.WIDTH(40), .DEPTH(DEPTH)) u_dv_ram (
        .clk   (clk),
        .we    (cmd.dv_we),
        .addr  (cmd.dv_addr[AW-1:0]),
        .wdata (dv_wdata),
        .rdata (dv_rdata)
    );

    assign status.last_point = in_reg.last_point;
    assign result            = out_reg;
    assign result_valid      = valid_reg;

endmodule

### hw/rtl/ncs_ctrl.sv
// ncs_ctrl: sequencer for store, forward sweep, back substitution and emission
// depends on ncs_pkg
module ncs_ctrl #(
    parameter int MAX_POINTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ncs_pkg::status_t status,
    output ncs_pkg::cmd_t    cmd
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PW    = 5'd1;
    localparam logic [4:0] S_R1    = 5'd2;
    localparam logic [4:0] S_R2    = 5'd3;
    localparam logic [4:0] S_T     = 5'd4;
    localparam logic [4:0] S_M1    = 5'd5;
    localparam logic [4:0] S_M2    = 5'd6;
    localparam logic [4:0] S_FW    = 5'd7;
    localparam logic [4:0] S_SOLVE = 5'd8;
    localparam logic [4:0] S_E1    = 5'd9;
    localparam logic [4:0] S_E2    = 5'd10;
    localparam logic [4:0] S_E3    = 5'd11;
    localparam logic [4:0] S_EW    = 5'd12;
    localparam logic [4:0] S_B1    = 5'd13;
    localparam logic [4:0] S_B2    = 5'd14;
    localparam logic [4:0] S_BW    = 5'd15;
    localparam logic [4:0] S_O1    = 5'd16;
    localparam logic [4:0] S_O2    = 5'd17;
    localparam logic [4:0] S_O3    = 5'd18;
    localparam logic [4:0] S_O4    = 5'd19;

    localparam logic [1:0] MODE_FWD = 2'd0;
    localparam logic [1:0] MODE_END = 2'd1;
    localparam logic [1:0] MODE_BWD = 2'd2;

    logic [4:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [CW-1:0] c_reg, c_next;
    logic [CW-1:0] i_reg, i_next;
    logic [1:0]    ax_reg, ax_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] n;
    logic [CW-1:0] prev_idx;

    function automatic logic [ncs_pkg::ADDR_W-1:0] addr_of(logic [CW-1:0] idx, logic [1:0] ax);
        return ncs_pkg::ADDR_W'({idx, 1'b0}) + ncs_pkg::ADDR_W'(idx) + ncs_pkg::ADDR_W'(ax);
    endfunction

    assign n        = c_reg - CW'(1);
    assign prev_idx = (c_reg >= CW'(2)) ? c_reg - CW'(2) : '0;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        c_next     = c_reg;
        i_next     = i_reg;
        ax_next    = ax_reg;
        drop_next  = drop_reg;
        cmd        = '0;
        cmd.op     = ncs_pkg::OP_NOP;
        cmd.ax     = ax_reg;
        cmd.seg    = 4'(i_reg);
        cmd.ovf    = drop_reg;
        busy       = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    ax_next     = 2'd0;
                    if (c_reg < CW'(MAX_POINTS))
                        state_next = S_PW;
                    else
                    begin
                        drop_next  = 1'b1;
                        state_next = S_SOLVE;
                    end
                end
            end
            S_PW:
            begin
                cmd.pt_addr = addr_of(c_reg, ax_reg);
                cmd.pt_we   = 1'b1;
                if (c_reg != '0)
                    state_next = S_R1;
                else if (ax_reg == 2'd2)
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = S_SOLVE;
                end
                else
                    ax_next = ax_reg + 2'd1;
            end
            S_R1:
            begin
                cmd.pt_addr = addr_of(prev_idx, ax_reg);
                cmd.fw_addr = addr_of(prev_idx, ax_reg);
                state_next  = S_R2;
            end
            S_R2:
            begin
                cmd.op     = ncs_pkg::OP_LD_FWD;
                mode_next  = MODE_FWD;
                state_next = S_T;
            end
            S_T:
            begin
                cmd.op = (mode_reg == MODE_BWD) ? ncs_pkg::OP_TERM_D : ncs_pkg::OP_TERM_PT;
                cmd.use_f = (mode_reg == MODE_END) || (c_reg >= CW'(2));
                cmd.gend  = (mode_reg == MODE_END);
                case (mode_reg)
                    MODE_FWD: cmd.gidx = ncs_pkg::IDX_W'(n);
                    MODE_END: cmd.gidx = ncs_pkg::IDX_W'(n);
                    default:  cmd.gidx = ncs_pkg::IDX_W'(i_reg);
                endcase
                state_next = S_M1;
            end
            S_M1:
            begin
                cmd.op     = ncs_pkg::OP_MUL;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd.op = ncs_pkg::OP_FIN;
                case (mode_reg)
                    MODE_FWD: state_next = S_FW;
                    MODE_END: state_next = S_EW;
                    default:  state_next = S_BW;
                endcase
            end
            S_FW:
            begin
                cmd.fw_addr = addr_of(n, ax_reg);
                cmd.fw_we   = 1'b1;
                if (ax_reg == 2'd2)
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = S_SOLVE;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_PW;
                end
            end
            S_SOLVE:
            begin
                ax_next = 2'd0;
                if (!status.last_point)
                    state_next = S_IDLE;
                else if (c_reg < CW'(2))
                begin
                    c_next     = '0;
                    drop_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_E1;
            end
            S_E1:
            begin
                cmd.pt_addr = addr_of(n, ax_reg);
                state_next  = S_E2;
            end
            S_E2:
            begin
                cmd.op      = ncs_pkg::OP_LD_V1;
                cmd.pt_addr = addr_of(n - CW'(1), ax_reg);
                cmd.fw_addr = addr_of(n - CW'(1), ax_reg);
                state_next  = S_E3;
            end
            S_E3:
            begin
                cmd.op     = ncs_pkg::OP_LD_V0F;
                mode_next  = MODE_END;
                state_next = S_T;
            end
            S_EW:
            begin
                cmd.fw_addr = addr_of(n, ax_reg);
                cmd.dv_addr = addr_of(n, ax_reg);
                cmd.fw_we   = 1'b1;
                cmd.dv_we   = 1'b1;
                if (ax_reg == 2'd2)
                begin
                    ax_next    = 2'd0;
                    i_next     = n - CW'(1);
                    state_next = S_B1;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_E1;
                end
            end
            S_B1:
            begin
                cmd.dv_addr = addr_of(i_reg + CW'(1), ax_reg);
                cmd.fw_addr = addr_of(i_reg, ax_reg);
                state_next  = S_B2;
            end
            S_B2:
            begin
                cmd.op     = ncs_pkg::OP_LD_BWD;
                mode_next  = MODE_BWD;
                state_next = S_T;
            end
            S_BW:
            begin
                cmd.dv_addr = addr_of(i_reg, ax_reg);
                cmd.dv_we   = 1'b1;
                cmd.dv_sub  = 1'b1;
                if (ax_reg != 2'd2)
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_B1;
                end
                else
                begin
                    ax_next = 2'd0;
                    if (i_reg == '0)
                        state_next = S_O1;
                    else
                    begin
                        i_next     = i_reg - CW'(1);
                        state_next = S_B1;
                    end
                end
            end
            S_O1:
            begin
                cmd.pt_addr = addr_of(i_reg, ax_reg);
                cmd.dv_addr = addr_of(i_reg, ax_reg);
                state_next  = S_O2;
            end
            S_O2:
            begin
                cmd.op      = ncs_pkg::OP_LD_LO;
                cmd.pt_addr = addr_of(i_reg + CW'(1), ax_reg);
                cmd.dv_addr = addr_of(i_reg + CW'(1), ax_reg);
                state_next  = S_O3;
            end
            S_O3:
            begin
                cmd.op     = ncs_pkg::OP_LD_HI;
                state_next = S_O4;
            end
            S_O4:
            begin
                cmd.op   = ncs_pkg::OP_EMIT;
                cmd.last = (i_reg == n - CW'(1)) && (ax_reg == 2'd2);
                if (ax_reg != 2'd2)
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_O1;
                end
                else
                begin
                    ax_next = 2'd0;
                    if (i_reg == n - CW'(1))
                    begin
                        c_next     = '0;
                        drop_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_O1;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_FWD;
            c_reg     <= '0;
            i_reg     <= '0;
            ax_reg    <= 2'd0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            c_reg     <= c_next;
            i_reg     <= i_next;
            ax_reg    <= ax_next;
            drop_reg  <= drop_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pt_we |-> (c_reg < CW'(MAX_POINTS)))
        else $error("point write beyond capacity");

    a_emit_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ncs_pkg::OP_EMIT) |-> (c_reg >= CW'(2)) && (i_reg < n))
        else $error("emission outside the stored set");

    a_bwd_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BW) |-> (i_reg < n))
        else $error("back substitution index out of range");

endmodule

### hw/rtl/natural_cubic_spline_coefficients.sv
// natural_cubic_spline_coefficients: top level of the 3-d natural cubic spline block
// depends on ncs_pkg, ncs_ctrl, ncs_datapath (and ncs_ram through it)
//
// usage: drive point and pulse start; a request is taken at a rising edge with start
// high and busy low. points are stored, each after the first with a forward sweep term; a point with
// last_point set closes the set and starts the solve. up to MAX_POINTS points are
// kept, later ones are dropped and every result of that set carries overflow.
// a stored point holds busy while each axis in turn is written and, but for the first of
// a set, put through the forward sweep, using the stores' single port and the shared
// gamma multiplier, and then while the end of the set is checked; a dropped point holds
// it only for that check. busy drops low between requests, so a new point is not taken
// before the last one is through. the solve then works out the end row, runs back
// substitution over the segments from the last down to the first and emits the
// segments from the first up, one result per axis; busy falls with the last strobe.
// each result sits on result for one cycle with result_valid high; the receiver
// cannot stall, so results are never held. a one-point set gives no result.
// reset clears the point count and the drop flag; the stores need no clearing.
module natural_cubic_spline_coefficients #(
    parameter int MAX_POINTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ncs_pkg::point_t  point,
    output ncs_pkg::result_t result,
    output logic             result_valid
);

    ncs_pkg::cmd_t    cmd;
    ncs_pkg::status_t status;

    ncs_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    ncs_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .point        (point),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
